// ===== hw/rtl/spg_pkg.sv =====
// Shared types and constants of the servo PWM generator.
// No dependencies; every other file of the block except spg_stream_if uses it.
package spg_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int COUNTER_WIDTH = 16;
    localparam int CH_IDX_W = $clog2(NUM_CHANNELS);
    localparam int PRESCALE_W = 7;
    localparam int SHIFT_W = 3;
    localparam int US_W = 16;
    localparam int PROD_W = US_W + 4;
    localparam int TICK_SHIFT = 3;

    localparam logic [COUNTER_WIDTH-1:0] RESET_PERIOD = 16'd37499;
    localparam logic [SHIFT_W-1:0] RESET_SHIFT = 3'd5;
    localparam logic [US_W-1:0] RESET_MIN_US = 16'd1000;
    localparam logic [US_W-1:0] RESET_MAX_US = 16'd2000;
    localparam logic [COUNTER_WIDTH-1:0] RESET_COMPARE = 16'd1875;
    localparam logic [PROD_W-1:0] TICK_MUL = 20'd15;
    localparam logic [COUNTER_WIDTH-1:0] TICKS_MAX = 16'hFFFF;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET = 1'b1;

    localparam logic [1:0] REG_PERIOD_TOP = 2'd0;
    localparam logic [1:0] REG_PRESCALE_SHIFT = 2'd1;
    localparam logic [1:0] REG_MIN_WIDTH_US = 2'd2;
    localparam logic [1:0] REG_MAX_WIDTH_US = 2'd3;

    typedef struct packed {
        logic opcode;
        logic [7:0] channel_sel;
        logic [US_W-1:0] width_us;
    } item_t;

    typedef struct packed {
        logic [NUM_CHANNELS-1:0] pwm_levels;
        logic [COUNTER_WIDTH-1:0] counter_now;
        logic [COUNTER_WIDTH-1:0] written_ticks;
        logic write_done;
    } result_t;

    typedef struct packed {
        logic [1:0] reg_index;
        logic [US_W-1:0] wdata;
    } cfg_word_t;

    typedef struct packed {
        logic [COUNTER_WIDTH-1:0] period_top;
        logic [SHIFT_W-1:0] prescale_shift;
        logic [US_W-1:0] min_width_us;
        logic [US_W-1:0] max_width_us;
    } cfg_t;

    typedef struct packed {
        logic valid;
        logic opcode;
        logic ch_hit;
        logic [CH_IDX_W-1:0] ch;
        logic [COUNTER_WIDTH-1:0] ticks;
    } stage_t;

endpackage

// ===== hw/rtl/spg_stream_if.sv =====
// Valid/ready channel carrying one word of a given payload type.
// Payload types come from spg_pkg.
interface spg_stream_if #(parameter type payload_t = logic);
    logic valid;
    logic ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/spg_cfg_regs.sv =====
// Configuration register file of the servo PWM generator.
// Depends on spg_pkg and spg_stream_if.
module spg_cfg_regs (
    input logic clk,
    input logic rst_n,
    spg_stream_if.sink cfg,
    output spg_pkg::cfg_t regs
);

    spg_pkg::cfg_t regs_reg;

    assign cfg.ready = rst_n;
    assign regs = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.period_top <= spg_pkg::RESET_PERIOD;
            regs_reg.prescale_shift <= spg_pkg::RESET_SHIFT;
            regs_reg.min_width_us <= spg_pkg::RESET_MIN_US;
            regs_reg.max_width_us <= spg_pkg::RESET_MAX_US;
        end
        else if (cfg.valid)
        begin
            case (cfg.data.reg_index)
                spg_pkg::REG_PERIOD_TOP:
                    regs_reg.period_top <= cfg.data.wdata;
                spg_pkg::REG_PRESCALE_SHIFT:
                    regs_reg.prescale_shift <= cfg.data.wdata[spg_pkg::SHIFT_W-1:0];
                spg_pkg::REG_MIN_WIDTH_US:
                    regs_reg.min_width_us <= cfg.data.wdata;
                spg_pkg::REG_MAX_WIDTH_US:
                    regs_reg.max_width_us <= cfg.data.wdata;
                default:
                    regs_reg <= regs_reg;
            endcase
        end
    end

endmodule

// ===== hw/rtl/spg_ingress.sv =====
// Input register: decodes the channel and converts the clamped pulse width to ticks.
// Depends on spg_pkg and spg_stream_if.
module spg_ingress (
    input logic clk,
    input logic rst_n,
    spg_stream_if.sink in_ch,
    input spg_pkg::cfg_t regs,
    input logic core_ready,
    output spg_pkg::stage_t stage
);

    spg_pkg::stage_t stage_reg;
    spg_pkg::stage_t stage_next;
    logic [spg_pkg::US_W-1:0] us_lo;
    logic [spg_pkg::US_W-1:0] us_clamped;
    logic [spg_pkg::PROD_W-1:0] prod;
    logic take;

    assign in_ch.ready = rst_n && (!stage_reg.valid || core_ready);
    assign take = in_ch.valid && in_ch.ready;
    assign stage = stage_reg;

    always_comb
    begin
        us_lo = (in_ch.data.width_us < regs.min_width_us) ? regs.min_width_us
                                                          : in_ch.data.width_us;
        us_clamped = (us_lo > regs.max_width_us) ? regs.max_width_us : us_lo;
        prod = spg_pkg::PROD_W'(us_clamped) * spg_pkg::TICK_MUL;
        stage_next.valid = 1'b1;
        stage_next.opcode = in_ch.data.opcode;
        stage_next.ch_hit = in_ch.data.channel_sel < 8'(spg_pkg::NUM_CHANNELS);
        stage_next.ch = in_ch.data.channel_sel[spg_pkg::CH_IDX_W-1:0];
        if (in_ch.data.opcode == spg_pkg::OP_TICK)
        begin
            stage_next.ticks = '0;
        end
        else if (prod[spg_pkg::PROD_W-1])
        begin
            stage_next.ticks = spg_pkg::TICKS_MAX;
        end
        else
        begin
            stage_next.ticks = prod[spg_pkg::PROD_W-2:spg_pkg::TICK_SHIFT];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else if (take)
        begin
            stage_reg <= stage_next;
        end
        else if (core_ready)
        begin
            stage_reg.valid <= 1'b0;
        end
    end

endmodule

// ===== hw/rtl/spg_core.sv =====
// Prescaler, period counter, compare registers and the result register.
// Depends on spg_pkg and spg_stream_if.
module spg_core (
    input logic clk,
    input logic rst_n,
    input spg_pkg::stage_t stage,
    input spg_pkg::cfg_t regs,
    output logic core_ready,
    spg_stream_if.source out_ch
);

    logic [spg_pkg::PRESCALE_W-1:0] prescale_count_reg;
    logic [spg_pkg::PRESCALE_W-1:0] prescale_count_next;
    logic [spg_pkg::COUNTER_WIDTH-1:0] period_count_reg;
    logic [spg_pkg::COUNTER_WIDTH-1:0] period_count_next;
    logic [spg_pkg::COUNTER_WIDTH-1:0] cmp_reg [spg_pkg::NUM_CHANNELS];
    logic [spg_pkg::COUNTER_WIDTH-1:0] cmp_next [spg_pkg::NUM_CHANNELS];
    logic [spg_pkg::PRESCALE_W-1:0] top;
    spg_pkg::result_t res_reg;
    spg_pkg::result_t res_next;
    logic res_valid_reg;
    logic take;

    assign core_ready = !res_valid_reg || out_ch.ready;
    assign take = stage.valid && core_ready;
    assign out_ch.valid = res_valid_reg;
    assign out_ch.data = res_reg;

    always_comb
    begin
        top = spg_pkg::PRESCALE_W'((8'd1 << regs.prescale_shift) - 8'd1);
        prescale_count_next = prescale_count_reg;
        period_count_next = period_count_reg;
        for (int i = 0; i < spg_pkg::NUM_CHANNELS; i++)
        begin
            cmp_next[i] = cmp_reg[i];
        end
        if (stage.opcode == spg_pkg::OP_TICK)
        begin
            if (prescale_count_reg >= top)
            begin
                prescale_count_next = '0;
                if (period_count_reg >= regs.period_top)
                begin
                    period_count_next = '0;
                end
                else
                begin
                    period_count_next = period_count_reg + 1'b1;
                end
            end
            else
            begin
                prescale_count_next = prescale_count_reg + 1'b1;
            end
        end
        else if (stage.ch_hit)
        begin
            cmp_next[stage.ch] = stage.ticks;
        end
        for (int i = 0; i < spg_pkg::NUM_CHANNELS; i++)
        begin
            res_next.pwm_levels[i] = period_count_next < cmp_next[i];
        end
        res_next.counter_now = period_count_next;
        res_next.written_ticks = stage.ticks;
        res_next.write_done = (stage.opcode == spg_pkg::OP_SET) && stage.ch_hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_count_reg <= '0;
            period_count_reg <= '0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < spg_pkg::NUM_CHANNELS; i++)
            begin
                cmp_reg[i] <= spg_pkg::RESET_COMPARE;
            end
        end
        else if (take)
        begin
            prescale_count_reg <= prescale_count_next;
            period_count_reg <= period_count_next;
            res_valid_reg <= 1'b1;
            for (int i = 0; i < spg_pkg::NUM_CHANNELS; i++)
            begin
                cmp_reg[i] <= cmp_next[i];
            end
        end
        else if (out_ch.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    a_idle_state_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(period_count_reg) && $stable(prescale_count_reg))
        else $error("Counter state moved without a word being processed.");

    a_set_holds_counter: assert property (@(posedge clk) disable iff (!rst_n)
        take && stage.opcode == spg_pkg::OP_SET |=> $stable(period_count_reg))
        else $error("A set word moved the period counter.");

    a_result_matches_counter: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> res_valid_reg && res_reg.counter_now == period_count_reg)
        else $error("Result counter does not match the period counter.");

    a_counter_steps_by_one: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> period_count_reg == $past(period_count_reg)
            || period_count_reg == $past(period_count_reg) + 1'b1
            || period_count_reg == '0)
        else $error("Period counter jumped.");

endmodule

// ===== hw/rtl/servo_pwm_generator_top.sv =====
// Four-channel edge-aligned servo PWM generator, top level; uses spg_pkg,
// spg_stream_if, spg_cfg_regs, spg_ingress and spg_core.
// An accepted word passes the ingress stage register and then the result register on its way to its result word;
// one word is taken every cycle, limited only by the result register being drained.
// Reset loads the default period, prescaler and pulse limits, clears both
// counters and sets every compare register to 1875.
module servo_pwm_generator_top (
    input logic clk,
    input logic rst_n,
    spg_stream_if.sink cfg,
    spg_stream_if.sink in_ch,
    spg_stream_if.source out_ch
);

    spg_pkg::cfg_t regs;
    spg_pkg::stage_t stage;
    logic core_ready;

    spg_cfg_regs u_cfg_regs (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg),
        .regs(regs)
    );

    spg_ingress u_ingress (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .regs(regs),
        .core_ready(core_ready),
        .stage(stage)
    );

    spg_core u_core (
        .clk(clk),
        .rst_n(rst_n),
        .stage(stage),
        .regs(regs),
        .core_ready(core_ready),
        .out_ch(out_ch)
    );

endmodule
